// File: sv/lcr_pkg.sv
// Package: shared constants, register codes and types for the load-cell serial reader.
`default_nettype none

package lcr_pkg;

    // Conversion shape
    localparam int SAMPLE_BITS  = 24;
    localparam int GAIN_PULSES  = 1;
    localparam int PULSES_TOTAL = SAMPLE_BITS + GAIN_PULSES;
    localparam int PULSE_W      = $clog2(PULSES_TOTAL + 1);

    // Field widths
    localparam int TICK_W   = 8;
    localparam int RAW_W    = 24;
    localparam int DIFF_W   = RAW_W + 1;
    localparam int SCALE_W  = 24;
    localparam int WEIGHT_W = 21;
    localparam int FRAC_W   = 24;

    // Multiplier split: scale factor is cut into two halves
    localparam int SPLIT_W  = SCALE_W / 2;
    localparam int PP_W     = DIFF_W + SPLIT_W + 1;
    localparam int SUM_W    = PP_W + SPLIT_W + 1;
    localparam int QUO_W    = SUM_W - FRAC_W;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 8'd3;

    // Register reset values
    localparam logic [TICK_W-1:0]  RST_SETTLE = 8'd50;
    localparam logic [TICK_W-1:0]  RST_HALF   = 8'd10;
    localparam logic [RAW_W-1:0]   RST_OFFSET = 24'd101350;
    localparam logic [SCALE_W-1:0] RST_SCALE  = 24'd917095;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_HIGH   = 2'd2,
        PH_LOW    = 2'd3
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0]  settle;
        logic [TICK_W-1:0]  half;
        logic [RAW_W-1:0]   offset;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    // One classified tick, handed from front to back
    typedef struct packed {
        logic                     clk_pin;
        logic                     sample_valid;
        logic [RAW_W-1:0]         raw;
        logic signed [DIFF_W-1:0] diff;
    } t_item;

endpackage

`default_nettype wire

// File: sv/load_cell_adc_serial_reader.sv
// Top level: configuration registers, sequencer front, item queue and weight back end.
//
//  Channel  Dir  Signals                          Item
//  s        in   i_s_tvalid/o_s_tready/i_s_tdata  tdata [0] data_pin (one time-base tick)
//  m        out  o_m_tvalid/i_m_tready/o_m_tdata  tdata [0] clock_pin [24:1] raw_count
//                o_m_tuser                        [45:25] weight; tuser [0] sample_valid
//  cfg      in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
//  One tick is accepted per clock cycle while the queue has room; its result passes the
//  queue, the product stage and the output register before it leaves.
//  The weight multiply is split in two 25x13 products, summed in the next stage.
//  Reset (synchronous, active low) returns the sequencer to idle and loads defaults.
//  A stalled output holds its item; ticks keep coming in until the 2-entry queue fills.
`default_nettype none

module load_cell_adc_serial_reader
    import lcr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]   i_s_tdata,   // [0] data_pin, [7:1] zero
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]       o_m_tdata,   // [0] clock_pin, [24:1] raw_count,
                                                      // [45:25] weight_centigrams,
                                                      // [47:46] zero
    output logic                         o_m_tuser,   // [0] sample_valid
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg  r_cfg;
    t_item w_front_item, w_q_item;
    logic  w_push, w_full, w_nonempty, w_pop;
    logic  w_clk_pin, w_sample_valid;
    logic [RAW_W-1:0] w_raw;
    logic signed [WEIGHT_W-1:0] w_weight;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_full;
    assign w_push      = i_s_tvalid && o_s_tready;

    // Decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle <= RST_SETTLE;
            r_cfg.half   <= RST_HALF;
            r_cfg.offset <= RST_OFFSET;
            r_cfg.scale  <= RST_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SETTLE: r_cfg.settle <= i_cfg_data[TICK_W-1:0];
                CFG_HALF:   r_cfg.half   <= i_cfg_data[TICK_W-1:0];
                CFG_OFFSET: r_cfg.offset <= i_cfg_data[RAW_W-1:0];
                CFG_SCALE:  r_cfg.scale  <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    lcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (w_push),
        .i_data_pin (i_s_tdata[0]),
        .o_item     (w_front_item)
    );

    lcr_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_front_item),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_item     (w_q_item)
    );

    lcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item_valid   (w_nonempty),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_clk_pin      (w_clk_pin),
        .o_sample_valid (w_sample_valid),
        .o_raw          (w_raw),
        .o_weight       (w_weight)
    );

    // Pack result item
    assign o_m_tdata = {2'b00, w_weight, w_raw, w_clk_pin};
    assign o_m_tuser = w_sample_valid;

endmodule

`default_nettype wire

// File: sv/lcr_front.sv
// Front: serial clock sequencer that turns each tick into a classified item.
`default_nettype none

module lcr_front
    import lcr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_push,
    input  wire logic  i_data_pin,
    output t_item      o_item
);

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_timer, n_timer;
    logic [PULSE_W-1:0]  r_pulse, n_pulse;
    logic [RAW_W-1:0]    r_shift, n_shift;

    logic [TICK_W-1:0]   w_timer_inc;
    logic [TICK_W-1:0]   w_half_len;
    logic                w_settle_done;
    logic                w_half_done;
    logic                w_last_pulse;

    // Phase timing
    assign w_timer_inc   = r_timer + TICK_W'(1);
    assign w_half_len    = (i_cfg.half == '0) ? TICK_W'(1) : i_cfg.half;
    assign w_settle_done = (w_timer_inc >= i_cfg.settle);
    assign w_half_done   = (w_timer_inc >= w_half_len);
    assign w_last_pulse  = (r_pulse >= PULSE_W'(PULSES_TOTAL));

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (!i_data_pin) begin
                    n_phase = (i_cfg.settle == '0) ? PH_HIGH : PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (w_settle_done) n_phase = PH_HIGH;
            end
            PH_HIGH: begin
                if (w_half_done) n_phase = PH_LOW;
            end
            PH_LOW: begin
                if (w_half_done) n_phase = w_last_pulse ? PH_IDLE : PH_HIGH;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Counters, shift register and item fields
    always_comb begin
        n_timer = r_timer;
        n_pulse = r_pulse;
        n_shift = r_shift;
        o_item  = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (!i_data_pin) begin
                    n_timer = '0;
                    n_pulse = '0;
                    n_shift = '0;
                end
            end
            PH_SETTLE: begin
                n_timer = w_settle_done ? '0 : w_timer_inc;
            end
            PH_HIGH: begin
                o_item.clk_pin = 1'b1;
                n_timer = w_half_done ? '0 : w_timer_inc;
                if (w_half_done) begin
                    // gain-select pulses shift nothing in
                    if (r_pulse < PULSE_W'(SAMPLE_BITS)) begin
                        n_shift = {r_shift[RAW_W-2:0], i_data_pin};
                    end
                    n_pulse = r_pulse + PULSE_W'(1);
                end
            end
            PH_LOW: begin
                n_timer = w_half_done ? '0 : w_timer_inc;
                if (w_half_done && w_last_pulse) begin
                    o_item.sample_valid = 1'b1;
                    o_item.raw          = r_shift;
                    o_item.diff         = $signed({1'b0, r_shift} - {1'b0, i_cfg.offset});
                end
            end
            default: ;
        endcase
    end

    // Advance on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_pulse <= '0;
            r_shift <= '0;
        end else if (i_push) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_pulse <= n_pulse;
            r_shift <= n_shift;
        end
    end

endmodule

`default_nettype wire

// File: sv/lcr_fifo.sv
// Short item queue that decouples the sequencer from the weight pipeline.
`default_nettype none

module lcr_fifo
    import lcr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_nonempty,
    output t_item      o_item
);

    t_item             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic w_push_ok;
    logic w_pop_ok;

    assign o_full     = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign w_push_ok  = i_push && !o_full;
    assign w_pop_ok   = i_pop && o_nonempty;

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/lcr_back.sv
// Back: two-stage weight pipeline (split multiply, then sum, floor shift, clamp).
`default_nettype none

module lcr_back
    import lcr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_item_valid,
    input  wire t_item                i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_clk_pin,
    output logic                      o_sample_valid,
    output logic [RAW_W-1:0]          o_raw,
    output logic signed [WEIGHT_W-1:0] o_weight
);

    localparam logic signed [QUO_W-1:0] W_MAX = QUO_W'((1 << (WEIGHT_W - 1)) - 1);
    localparam logic signed [QUO_W-1:0] W_MIN = -QUO_W'(1 << (WEIGHT_W - 1));

    logic                     r_v1;
    logic                     r_clk1, r_sv1;
    logic [RAW_W-1:0]         r_raw1;
    logic signed [PP_W-1:0]   r_plo, r_phi;

    logic                     r_ov;
    logic                     r_oclk, r_osv;
    logic [RAW_W-1:0]         r_oraw;
    logic signed [WEIGHT_W-1:0] r_owt;

    logic                     w_en_out, w_en1;
    logic signed [SPLIT_W:0]  w_lo, w_hi;
    logic signed [PP_W-1:0]   w_plo, w_phi;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [QUO_W-1:0]  w_quo;
    logic signed [WEIGHT_W-1:0] w_wt;

    // Stall chain from the output side
    assign w_en_out = !r_ov || i_ready;
    assign w_en1    = !r_v1 || w_en_out;
    assign o_pop    = i_item_valid && w_en1;

    // Partial products of the signed difference and each scale half
    assign w_lo  = $signed({1'b0, i_cfg.scale[SPLIT_W-1:0]});
    assign w_hi  = $signed({1'b0, i_cfg.scale[SCALE_W-1:SPLIT_W]});
    assign w_plo = PP_W'(i_item.diff) * PP_W'(w_lo);
    assign w_phi = PP_W'(i_item.diff) * PP_W'(w_hi);

    // Recombine, floor-shift and clamp
    assign w_sum = $signed({{(SUM_W - PP_W - SPLIT_W){r_phi[PP_W-1]}}, r_phi,
                            {SPLIT_W{1'b0}}})
                 + $signed({{(SUM_W - PP_W){r_plo[PP_W-1]}}, r_plo});
    assign w_quo = w_sum[SUM_W-1:FRAC_W];

    always_comb begin
        if (w_quo > W_MAX) begin
            w_wt = W_MAX[WEIGHT_W-1:0];
        end else if (w_quo < W_MIN) begin
            w_wt = W_MIN[WEIGHT_W-1:0];
        end else begin
            w_wt = w_quo[WEIGHT_W-1:0];
        end
    end

    // Hold stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1)    r_v1 <= i_item_valid;
            if (w_en_out) r_ov <= r_v1;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_clk1 <= i_item.clk_pin;
            r_sv1  <= i_item.sample_valid;
            r_raw1 <= i_item.raw;
            r_plo  <= w_plo;
            r_phi  <= w_phi;
        end
        if (w_en_out) begin
            r_oclk <= r_clk1;
            r_osv  <= r_sv1;
            r_oraw <= r_raw1;
            r_owt  <= r_sv1 ? w_wt : '0;
        end
    end

    assign o_valid        = r_ov;
    assign o_clk_pin      = r_oclk;
    assign o_sample_valid = r_osv;
    assign o_raw          = r_oraw;
    assign o_weight       = r_owt;

endmodule

`default_nettype wire

// File: sv/lcr_chk.sv
// Port checker for the load-cell serial reader, bound to the top level.
`default_nettype none

module lcr_chk
    import lcr_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tuser
);

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable({o_m_tuser, o_m_tdata}))
        else $error("result payload changed while stalled");

    // A tick without a finished conversion carries no count and no weight
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata[45:1] == '0))
        else $error("count or weight present without a finished conversion");

    // A conversion finishes at the end of a low phase
    a_done_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> !o_m_tdata[0])
        else $error("conversion reported with serial clock high");

endmodule

bind load_cell_adc_serial_reader lcr_chk u_lcr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
